@@ sv/amps_pkg.sv @@
`timescale 1ns / 1ps
// shared constants for the moving average pulse scaler
// no dependencies; used by the core and its checker

package amps_pkg;

    localparam int AVG_DEPTH_DEF = 16;

    localparam int DATA_W   = 10;
    localparam int OFFSET_W = 16;
    localparam int SPAN_W   = 21;
    localparam int CFG_W    = 21;
    localparam int TDATA_W  = 16;
    localparam int FRAC_W   = 6;
    localparam int DIFF_W   = DATA_W + FRAC_W + 1;
    localparam int DMAG_W   = DIFF_W - 1;
    localparam int PROD_W   = DMAG_W + SPAN_W;
    localparam int PROD_SH  = 18;

    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(4000);
    localparam logic [DATA_W-1:0] RES_MIN    = DATA_W'(1);
    localparam logic [DATA_W-1:0] RES_MAX    = DATA_W'(1000);

    typedef enum logic
    {
        REG_OFFSET = 1'b0,
        REG_SPAN   = 1'b1
    } reg_index_t;

endpackage

@@ sv/adc_moving_average_pulse_scaler_core.sv @@
`timescale 1ns / 1ps
// adc sample boxcar average, offset, span scaling and clamp to 1..1000
// depends on amps_pkg
//
// One request at a time: a sample is taken, averaged over the last AVG_DEPTH
// samples (fewer until the ring has filled) by a bit-serial restoring divider,
// offset-corrected, then scaled by a bit-serial shift-add multiplier. The
// finished result sits in an output register, so a new sample is taken while
// the previous result waits. The sample ring is a memory with no clearing
// pass: old entries are subtracted from the sum only once the ring has been
// filled. Configuration is to be written through cfg_we/cfg_index/cfg_data
// only while the block is idle; the user must keep to this, as the block does
// not enforce it.

module adc_moving_average_pulse_scaler_core #(
    parameter int AVG_DEPTH = amps_pkg::AVG_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [amps_pkg::TDATA_W-1:0] s_tdata,   // [9:0] adc_sample
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [amps_pkg::TDATA_W-1:0] m_tdata,   // [9:0] pulse_tenths_ms
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [amps_pkg::CFG_W-1:0]   cfg_data
);

    localparam int SUM_W     = amps_pkg::DATA_W + $clog2(AVG_DEPTH);
    localparam int CNT_W     = $clog2(AVG_DEPTH + 1);
    localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int MAX_STEPS = (SUM_W > amps_pkg::DMAG_W) ? SUM_W : amps_pkg::DMAG_W;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int DW        = amps_pkg::DATA_W;
    localparam int QW        = amps_pkg::PROD_W - amps_pkg::PROD_SH;

    typedef enum logic [5:0]
    {
        S_IDLE = 6'b000001,
        S_SUM  = 6'b000010,
        S_DIV  = 6'b000100,
        S_DIFF = 6'b001000,
        S_MUL  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [DW-1:0] ring [AVG_DEPTH];
    logic [DW-1:0] old_reg;
    logic [DW-1:0] sample_reg;
    logic          full_reg;

    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [amps_pkg::SPAN_W-1:0] mcand_reg, mcand_next;
    logic [amps_pkg::DMAG_W-1:0] mplier_reg, mplier_next;
    logic [amps_pkg::PROD_W-1:0] acc_reg, acc_next;

    logic [amps_pkg::OFFSET_W-1:0] offset_reg;
    logic [amps_pkg::SPAN_W-1:0]   span_reg;

    logic          out_valid_reg;
    logic [DW-1:0] out_data_reg;

    logic                 accept;
    logic                 full;
    logic [CNT_W:0]       trial;
    logic signed [amps_pkg::DIFF_W-1:0] diff;
    logic [amps_pkg::DIFF_W-1:0]        diff_abs;
    logic [amps_pkg::SPAN_W-1:0]        span_abs;
    logic [QW-1:0]        quot;
    logic [DW-1:0]        res;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (cnt_reg == CNT_W'(AVG_DEPTH));
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(amps_pkg::TDATA_W - DW){1'b0}}, out_data_reg};

    // sample ring, read-before-write at the current slot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring[slot_reg] <= s_tdata[DW-1:0];
            old_reg        <= ring[slot_reg];
            sample_reg     <= s_tdata[DW-1:0];
        end
    end

    always_comb
    begin
        trial       = {rem_reg, dvd_reg[SUM_W-1]};
        diff        = $signed({1'b0, dvd_reg[DW-1:0], {amps_pkg::FRAC_W{1'b0}}})
                    - $signed({1'b0, offset_reg});
        diff_abs    = diff[amps_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
        span_abs    = span_reg[amps_pkg::SPAN_W-1] ? (~span_reg + 1'b1) : span_reg;
        quot        = acc_reg[amps_pkg::PROD_W-1:amps_pkg::PROD_SH];
        if (quot == '0)
        begin
            res = amps_pkg::RES_MIN;
        end
        else if (quot >= QW'(amps_pkg::RES_MAX))
        begin
            res = amps_pkg::RES_MAX;
        end
        else
        begin
            res = quot[DW-1:0];
        end

        state_next  = state_reg;
        sum_next    = sum_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                sum_next   = sum_reg - (full_reg ? SUM_W'(old_reg) : '0) + SUM_W'(sample_reg);
                dvd_next   = sum_next;
                rem_next   = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // one quotient bit per cycle
                if (trial >= {1'b0, cnt_reg})
                begin
                    rem_next = CNT_W'(trial - {1'b0, cnt_reg});
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                // opposite signs give a negative product, clamped low anyway
                mcand_next  = (diff[amps_pkg::DIFF_W-1] != span_reg[amps_pkg::SPAN_W-1])
                            ? '0 : span_abs;
                mplier_next = diff_abs[amps_pkg::DMAG_W-1:0];
                acc_next    = '0;
                step_next   = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                // msb-first shift-add
                acc_next    = {acc_reg[amps_pkg::PROD_W-2:0], 1'b0}
                            + (mplier_reg[amps_pkg::DMAG_W-1]
                               ? amps_pkg::PROD_W'(mcand_reg) : '0);
                mplier_next = {mplier_reg[amps_pkg::DMAG_W-2:0], 1'b0};
                step_next   = step_reg + 1'b1;
                if (step_reg == STEP_W'(amps_pkg::DMAG_W - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            offset_reg    <= '0;
            span_reg      <= amps_pkg::SPAN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    amps_pkg::REG_OFFSET:
                    begin
                        offset_reg <= cfg_data[amps_pkg::OFFSET_W-1:0];
                    end
                    amps_pkg::REG_SPAN:
                    begin
                        span_reg <= cfg_data[amps_pkg::SPAN_W-1:0];
                    end
                    default:
                    begin
                        offset_reg <= offset_reg;
                    end
                endcase
            end

            if (accept)
            begin
                full_reg <= full;
                if (!full)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (slot_reg == SLOT_W'(AVG_DEPTH - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end

            if (state_reg == S_OUT && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        if (state_reg == S_OUT && (!out_valid_reg || m_tready))
        begin
            out_data_reg <= res;
        end
    end

endmodule

@@ sv/amps_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the moving average pulse scaler core
// depends on amps_pkg; bound to adc_moving_average_pulse_scaler_core

module amps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [amps_pkg::TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // result always inside the clamp window
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= amps_pkg::TDATA_W'(amps_pkg::RES_MIN))
                  && (m_tdata <= amps_pkg::TDATA_W'(amps_pkg::RES_MAX)))
        else $error("result outside clamp range");

    // one request in flight
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new request taken while busy");

    // a result cannot appear right after an accept
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind adc_moving_average_pulse_scaler_core amps_checker u_amps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/adc_moving_average_pulse_scaler_core_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for the moving average pulse scaler core: directed table then random phases
// depends on amps_pkg and adc_moving_average_pulse_scaler_core

module adc_moving_average_pulse_scaler_core_test;

    localparam int DEPTH          = amps_pkg::AVG_DEPTH_DEF;
    localparam int ITEM_CYCLES    = 34;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 160;
    localparam int PRINT_CAP      = 40;
    localparam int PLAN_ROWS      = 27;

    typedef enum logic
    {
        ROW_SAMPLE = 1'b0,
        ROW_CONFIG = 1'b1
    } row_kind_t;

    typedef enum logic [1:0]
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum logic [1:0]
    {
        STYLE_UNIFORM,
        STYLE_WALK,
        STYLE_RAILS,
        STYLE_STEADY
    } sample_style_t;

    typedef struct packed
    {
        row_kind_t                    kind;
        amps_pkg::reg_index_t         reg_sel;
        logic [amps_pkg::CFG_W-1:0]   cfg_value;
        logic [amps_pkg::TDATA_W-1:0] word;
        logic                         typed;
        logic [amps_pkg::DATA_W-1:0]  typed_pulse;
    } stim_row_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [amps_pkg::TDATA_W-1:0]  s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [amps_pkg::TDATA_W-1:0]  m_tdata;
    logic                          cfg_we    = 1'b0;
    logic                          cfg_index = amps_pkg::REG_OFFSET;
    logic [amps_pkg::CFG_W-1:0]    cfg_data  = '0;

    // model state of the averager and its registers
    logic [amps_pkg::DATA_W-1:0]   avg_ring [DEPTH];
    logic [13:0]                   avg_sum   = '0;
    logic [3:0]                    ring_slot = '0;
    logic [4:0]                    ring_fill = '0;
    logic [amps_pkg::OFFSET_W-1:0] offset_q6 = '0;
    logic [amps_pkg::SPAN_W-1:0]   span_q12  = amps_pkg::SPAN_RESET;

    logic [amps_pkg::DATA_W-1:0]   pulse_expected [$];
    int                            mismatch_count = 0;
    int                            gap_pct        = 0;
    int                            stall_pct      = 0;
    int                            idle_cycles;

    sample_style_t       burst_style = STYLE_UNIFORM;
    int                  burst_left  = 0;
    int                  walk_level  = 512;

    stim_row_t plan_rows [PLAN_ROWS] = '{
        // empty ring averages to zero
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0000, 1'b1, 10'd1},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'hFFFF, 1'b0, 10'd0}, // extra tdata bits set
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h03FF, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h7A00, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0155, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'hFEAA, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0001, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0002, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0004, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0008, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0010, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0020, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0040, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0080, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0100, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h03E8, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h03E7, 1'b0, 10'd0}, // ring wraps
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h03FF, 1'b0, 10'd0},
        '{ROW_CONFIG, amps_pkg::REG_OFFSET, 21'h1FFFFF, 16'h0000, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h03FF, 1'b1, 10'd1}, // average below offset
        '{ROW_CONFIG, amps_pkg::REG_OFFSET, 21'd0, 16'h0000, 1'b0, 10'd0},
        '{ROW_CONFIG, amps_pkg::REG_SPAN, 21'h0FFFFF, 16'h0000, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h03FF, 1'b1, 10'd1000}, // clamps high
        '{ROW_CONFIG, amps_pkg::REG_SPAN, 21'h100000, 16'h0000, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h0000, 1'b1, 10'd1},    // negative span
        '{ROW_CONFIG, amps_pkg::REG_SPAN, 21'd0, 16'h0000, 1'b0, 10'd0},
        '{ROW_SAMPLE, amps_pkg::REG_OFFSET, 21'd0, 16'h03FF, 1'b1, 10'd1}     // zero span
    };

    adc_moving_average_pulse_scaler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [9:0] adc_sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [9:0] pulse_tenths_ms
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        foreach (avg_ring[i])
        begin
            avg_ring[i] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("%0t ns  %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // boxcar average, offset, span, truncate and clamp
    function automatic logic [amps_pkg::DATA_W-1:0] scale_sample(
        input logic [amps_pkg::DATA_W-1:0] adc);
        logic [13:0] mean;
        longint      diff;
        longint      prod;
        longint      q;
        avg_sum = avg_sum - 14'(avg_ring[ring_slot]) + 14'(adc);
        avg_ring[ring_slot] = adc;
        ring_slot = ring_slot + 4'd1;
        if (ring_fill < 5'(DEPTH))
        begin
            ring_fill = ring_fill + 5'd1;
        end
        mean = avg_sum / 14'(ring_fill);
        diff = longint'(mean) * 64 - longint'(offset_q6);
        prod = diff * longint'($signed(span_q12));
        if (prod <= 0)
        begin
            return amps_pkg::RES_MIN;
        end
        q = prod >>> amps_pkg::PROD_SH;
        if (q == 0)
        begin
            return amps_pkg::RES_MIN;
        end
        if (q >= longint'(amps_pkg::RES_MAX))
        begin
            return amps_pkg::RES_MAX;
        end
        return q[amps_pkg::DATA_W-1:0];
    endfunction

    function automatic logic [amps_pkg::TDATA_W-1:0] next_adc_word();
        logic [amps_pkg::DATA_W-1:0] adc;
        if (burst_left == 0)
        begin
            burst_style = sample_style_t'($urandom_range(3));
            burst_left  = $urandom_range(48, 16);
            walk_level  = $urandom_range(1023);
        end
        burst_left--;
        case (burst_style)
            STYLE_UNIFORM: adc = amps_pkg::DATA_W'($urandom_range(1023));
            STYLE_WALK:
            begin
                walk_level = walk_level + int'($urandom_range(40)) - 20;
                if (walk_level < 0)
                begin
                    walk_level = 0;
                end
                if (walk_level > 1023)
                begin
                    walk_level = 1023;
                end
                adc = amps_pkg::DATA_W'(walk_level);
            end
            STYLE_RAILS:   adc = $urandom_range(1) ? 10'h3FF : 10'h000;
            default:       adc = amps_pkg::DATA_W'(walk_level);
        endcase
        return {6'($urandom_range(63)), adc};
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        gap_pct   = (mode == IDLE_SENDER) ? 46 : (mode == IDLE_BOTH) ? 31 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 46 : (mode == IDLE_BOTH) ? 31 : 0;
    endtask

    // one request on the sample side; model updated at acceptance
    task automatic push_sample(input logic [amps_pkg::TDATA_W-1:0] word, input logic typed,
                               input logic [amps_pkg::DATA_W-1:0] typed_pulse);
        logic [amps_pkg::DATA_W-1:0] predicted;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = scale_sample(word[amps_pkg::DATA_W-1:0]);
        pulse_expected.push_back(typed ? typed_pulse : predicted);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pulse_expected.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input amps_pkg::reg_index_t sel,
                             input logic [amps_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == amps_pkg::REG_OFFSET)
        begin
            offset_q6 = value[amps_pkg::OFFSET_W-1:0];
        end
        else
        begin
            span_q12 = value[amps_pkg::SPAN_W-1:0];
        end
    endtask

    task automatic pick_config();
        logic [amps_pkg::OFFSET_W-1:0] offset;
        logic [amps_pkg::SPAN_W-1:0]   span;
        case ($urandom_range(5))
            0:       offset = '0;
            1:       offset = 16'hFFFF;
            2:       offset = amps_pkg::OFFSET_W'($urandom);
            default: offset = amps_pkg::OFFSET_W'($urandom_range(40000));
        endcase
        case ($urandom_range(7))
            0:       span = 21'h0FFFFF;
            1:       span = 21'h100000;
            2:       span = '0;
            3:       span = amps_pkg::SPAN_RESET;
            4:       span = amps_pkg::SPAN_W'($urandom);
            default: span = amps_pkg::SPAN_W'($urandom_range(12000, 1));
        endcase
        write_reg(amps_pkg::REG_OFFSET, {5'($urandom_range(31)), offset});
        write_reg(amps_pkg::REG_SPAN, span);
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        logic [amps_pkg::DATA_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pulse_expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pulse %0d", m_tdata));
            end
            else
            begin
                want = pulse_expected.pop_front();
                if (m_tdata !== {{(amps_pkg::TDATA_W-amps_pkg::DATA_W){1'b0}}, want})
                begin
                    report_mismatch($sformatf("pulse_tenths_ms got %0d want %0d",
                                              m_tdata, want));
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        set_idle(IDLE_NONE);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan_rows[r])
        begin
            if (plan_rows[r].kind == ROW_CONFIG)
            begin
                wait_drained();
                write_reg(plan_rows[r].reg_sel, plan_rows[r].cfg_value);
            end
            else
            begin
                push_sample(plan_rows[r].word, plan_rows[r].typed, plan_rows[r].typed_pulse);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            pick_config();
            set_idle(idle_mode_t'(p % 4));
            repeat (PHASE_ITEMS) push_sample(next_adc_word(), 1'b0, '0);
        end

        wait_drained();
        repeat (2 * ITEM_CYCLES) @(posedge clk);
        if (pulse_expected.size() != 0)
        begin
            report_mismatch($sformatf("%0d pulses never arrived", pulse_expected.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/amps_pkg.sv
sv/adc_moving_average_pulse_scaler_core.sv
sv/amps_checker.sv
tb/adc_moving_average_pulse_scaler_core_test.sv
